/* hw/rtl/sle_pkg.sv */
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and codes for the sorted list engine: request and result
// words, the per-cell control word, action and status codes.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int ValueWidth = 32;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_SEARCH = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [1:0]                   action;
    logic signed [ValueWidth-1:0] value;
  } req_word_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic                         found;
    logic [4:0]                   item_count;
    logic signed [ValueWidth-1:0] smallest;
    logic signed [ValueWidth-1:0] largest;
    logic                         is_empty;
  } rsp_word_t;

  typedef struct packed {
    logic                         ins;
    logic                         del;
    logic signed [ValueWidth-1:0] value;
  } cell_ctl_t;

endpackage

/* hw/rtl/sle_cell.sv */
// ----------------------------------------------------------------------------
// sle_cell
// One slot of the sorted chain. It compares its value with the request and
// either keeps it, takes the new value, or takes a neighbor's value.
// ----------------------------------------------------------------------------
module sle_cell
  import sle_pkg::*;
(
  input  logic                         clk,
  input  logic                         occ,
  input  cell_ctl_t                    ctl,
  input  logic                         left_le,
  input  logic signed [ValueWidth-1:0] left_val,
  input  logic signed [ValueWidth-1:0] right_val,
  output logic signed [ValueWidth-1:0] val,
  output logic                         le,
  output logic                         eq
);

  logic ge;

  assign le = occ && (val <= ctl.value);
  assign ge = occ && (val >= ctl.value);
  assign eq = occ && (val == ctl.value);

  always_ff @(posedge clk) begin
    if (ctl.ins && !le) begin
      val <= left_le ? ctl.value : left_val;
    end else if (ctl.del && ge) begin
      val <= right_val;
    end
  end

endmodule

/* hw/rtl/sorted_list_engine.sv */
// ----------------------------------------------------------------------------
// sorted_list_engine
// Keeps up to CAPACITY signed values in ascending order in a chain of cells.
// ----------------------------------------------------------------------------
// Each request word on the in channel asks to insert a value, delete one
// occurrence of it, or search for it. Every request yields exactly one result
// word on the out channel with a status, a found flag, the count, the
// smallest and largest stored values and an empty flag.
// All cells compare against the request in parallel and shift by one slot in
// the cycle the word is accepted, so the store is updated at that edge. The
// result is formed from the updated cells as it moves from a pending stage
// into the output register that drives the out channel.
// A new request word can be accepted every cycle as long as the out channel
// keeps taking results. When the receiver stalls, the result is held in the
// output register and one more request can still be accepted; its result
// waits in a pending stage, and in_stall rises only while both are full.
// Reset empties the store and clears both channels; no clearing pass is run.
// ----------------------------------------------------------------------------
module sorted_list_engine
  import sle_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  req_word_t in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output rsp_word_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] count;
  logic          pending;
  logic [1:0]    pend_status;
  logic          pend_found;

  logic signed [ValueWidth-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]          occ;
  logic [CAPACITY-1:0]          last;
  logic [CAPACITY-1:0]          le;
  logic [CAPACITY-1:0]          eq;

  cell_ctl_t ctl;
  logic      accept;
  logic      out_free;
  logic      hit;
  logic      full;
  logic [1:0] status_next;
  logic signed [ValueWidth-1:0] largest_sel;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = pending && !out_free;
  assign accept   = in_valid && !in_stall;
  assign hit      = |eq;
  assign full     = (count == CW'(CAPACITY));

  assign ctl.value = in_data.value;
  assign ctl.ins   = accept && (in_data.action == ACT_INSERT) && !full;
  assign ctl.del   = accept && (in_data.action == ACT_DELETE) && hit;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    assign occ[g] = (count > CW'(g));
    if (g == CAPACITY - 1) begin : g_end
      assign last[g] = occ[g];
    end else begin : g_mid
      assign last[g] = occ[g] && !occ[g+1];
    end

    sle_cell u_cell (
      .clk       (clk),
      .occ       (occ[g]),
      .ctl       (ctl),
      .left_le   ((g == 0) ? 1'b1 : le[(g == 0) ? 0 : g-1]),
      .left_val  (cell_val[(g == 0) ? 0 : g-1]),
      .right_val (cell_val[(g == CAPACITY - 1) ? g : g+1]),
      .val       (cell_val[g]),
      .le        (le[g]),
      .eq        (eq[g])
    );
  end

  always_comb begin
    largest_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      largest_sel = largest_sel | (cell_val[i] & {ValueWidth{last[i]}});
    end
  end

  always_comb begin
    status_next = ST_OK;
    unique case (in_data.action)
      ACT_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end
      end
      ACT_DELETE: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else if (!hit) begin
          status_next = ST_ABSENT;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.ins) begin
        count <= count + CW'(1);
      end else if (ctl.del) begin
        count <= count - CW'(1);
      end
      if (pending && out_free) begin
        out_valid <= 1'b1;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        pending <= 1'b1;
      end else if (out_free) begin
        pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= status_next;
      pend_found  <= hit && ((in_data.action == ACT_SEARCH) || (in_data.action == ACT_DELETE));
    end
    if (pending && out_free) begin
      out_data.status     <= pend_status;
      out_data.found      <= pend_found;
      out_data.item_count <= 5'(count);
      out_data.is_empty   <= (count == '0);
      out_data.smallest   <= (count == '0) ? '0 : cell_val[0];
      out_data.largest    <= (count == '0) ? '0 : largest_sel;
    end
  end

endmodule

/* bench/sorted_list_engine_tb.sv */
// ----------------------------------------------------------------------------
// sorted_list_engine_tb
// Self-checking bench for the sorted list engine.
// ----------------------------------------------------------------------------
// A short table of directed requests covers the empty store, the unused
// action code, the value extremes, duplicates, an absent delete and a full
// store. A long run of random requests follows. It alternates between filling
// and draining the store so that both the full and the empty cases recur.
// A behavioral copy of the sorted store predicts each result word that the
// table leaves open. Both channels idle at random, and the receiver holds
// off for long stretches so that the engine backs up and stalls its request channel.
// ----------------------------------------------------------------------------
module sorted_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sle_pkg::*;

  localparam int Capacity = 16;
  localparam int RandomItems = 950;
  localparam logic [1:0] ActUnused = 2'd3;
  localparam logic signed [ValueWidth-1:0] MinValue = 32'sh8000_0000;
  localparam logic signed [ValueWidth-1:0] MaxValue = 32'sh7fff_ffff;

  typedef struct packed {
    req_word_t req;
    logic      typed;
    rsp_word_t rsp;
  } stim_row_t;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  req_word_t in_data;
  logic      out_valid;
  logic      out_stall;
  rsp_word_t out_data;

  logic signed [ValueWidth-1:0] list_vals [Capacity];
  int                           list_count;
  bit                           filling;
  int                           errors;
  rsp_word_t                    rsp_expected_q [$];
  stim_row_t                    stim_table [$];

  sorted_list_engine #(
    .CAPACITY(Capacity)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("** sorted_list_engine: FAILED **");
    $finish;
  end

  function automatic rsp_word_t mk_rsp(input logic [1:0] status, input logic found,
                                       input int count,
                                       input logic signed [ValueWidth-1:0] lo,
                                       input logic signed [ValueWidth-1:0] hi,
                                       input logic empty);
    rsp_word_t r;
    r.status = status;
    r.found = found;
    r.item_count = 5'(count);
    r.smallest = lo;
    r.largest = hi;
    r.is_empty = empty;
    return r;
  endfunction

  function automatic int find_value(input logic signed [ValueWidth-1:0] v);
    for (int i = 0; i < list_count; i++) begin
      if (list_vals[i] == v) return i;
    end
    return list_count;
  endfunction

  function automatic rsp_word_t apply_to_list(input req_word_t w);
    rsp_word_t                    r;
    logic signed [ValueWidth-1:0] v;
    int                           pos;
    r = '0;
    v = w.value;
    case (w.action)
      ACT_INSERT: begin
        if (list_count >= Capacity) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < list_count && list_vals[pos] <= v) pos++;
          for (int k = list_count; k > pos; k--) list_vals[k] = list_vals[k - 1];
          list_vals[pos] = v;
          list_count++;
        end
      end
      ACT_DELETE: begin
        if (list_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          pos = find_value(v);
          if (pos >= list_count) begin
            r.status = ST_ABSENT;
          end else begin
            for (int k = pos; k + 1 < list_count; k++) list_vals[k] = list_vals[k + 1];
            list_count--;
            r.found = 1'b1;
          end
        end
      end
      ACT_SEARCH: begin
        r.found = (find_value(v) < list_count);
      end
      default: begin
      end
    endcase
    r.item_count = 5'(list_count);
    r.is_empty = (list_count == 0);
    if (list_count != 0) begin
      r.smallest = list_vals[0];
      r.largest = list_vals[list_count - 1];
    end
    return r;
  endfunction

  function automatic logic signed [ValueWidth-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return MinValue;
      1: return MaxValue;
      2, 3, 4, 5: return $signed(32'($urandom_range(0, 16))) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_word_t next_random_req();
    req_word_t w;
    int        r;
    r = $urandom_range(0, 99);
    if (list_count >= Capacity) filling = 1'b0;
    else if (list_count == 0) filling = 1'b1;
    if (r < 5) w.action = ActUnused;
    else if (r < (filling ? 65 : 30)) w.action = ACT_INSERT;
    else if (r < 85) w.action = ACT_DELETE;
    else w.action = ACT_SEARCH;
    if (w.action != ACT_INSERT && list_count > 0 && $urandom_range(0, 9) < 7)
      w.value = list_vals[$urandom_range(0, list_count - 1)];
    else
      w.value = pick_value();
    return w;
  endfunction

  task automatic add_row(input logic [1:0] action, input logic signed [ValueWidth-1:0] value,
                         input logic typed, input rsp_word_t rsp);
    stim_row_t row;
    row.req.action = action;
    row.req.value = value;
    row.typed = typed;
    row.rsp = rsp;
    stim_table.push_back(row);
  endtask

  task automatic send_word(input req_word_t w, input logic typed, input rsp_word_t typed_rsp,
                           input bit may_idle);
    int        gap;
    rsp_word_t predicted;
    gap = may_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    predicted = apply_to_list(w);
    rsp_expected_q.push_back(typed ? typed_rsp : predicted);
    @(negedge clk);
  endtask

  task automatic report_field(input string name, input logic [ValueWidth-1:0] want,
                              input logic [ValueWidth-1:0] got);
    $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    errors++;
  endtask

  task automatic check_result(input rsp_word_t got);
    rsp_word_t want;
    if (rsp_expected_q.size() == 0) begin
      $display("%0t: result word with nothing expected, actual %h", $time, got);
      errors++;
    end else begin
      want = rsp_expected_q.pop_front();
      if (got.status !== want.status) report_field("status", want.status, got.status);
      if (got.found !== want.found) report_field("found", want.found, got.found);
      if (got.item_count !== want.item_count)
        report_field("item_count", want.item_count, got.item_count);
      if (got.smallest !== want.smallest) report_field("smallest", want.smallest, got.smallest);
      if (got.largest !== want.largest) report_field("largest", want.largest, got.largest);
      if (got.is_empty !== want.is_empty) report_field("is_empty", want.is_empty, got.is_empty);
    end
  endtask

  initial begin : rsp_side
    int gap;
    int taken;
    out_stall = 1'b0;
    taken = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (taken == 300 || taken == 700) gap = 60;
      else if (taken >= 100 && taken < 250) gap = 0;
      else gap = $urandom_range(0, 7);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      check_result(out_data);
      taken++;
      @(negedge clk);
    end
  end

  initial begin : req_side
    int        sent;
    req_word_t w;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    list_count = 0;
    filling = 1'b1;
    errors = 0;

    add_row(ACT_SEARCH, 0, 1'b1, mk_rsp(ST_OK, 1'b0, 0, 0, 0, 1'b1));
    add_row(ACT_DELETE, 5, 1'b1, mk_rsp(ST_EMPTY, 1'b0, 0, 0, 0, 1'b1));
    add_row(ActUnused, 7, 1'b1, mk_rsp(ST_OK, 1'b0, 0, 0, 0, 1'b1));
    add_row(ACT_INSERT, MinValue, 1'b1, mk_rsp(ST_OK, 1'b0, 1, MinValue, MinValue, 1'b0));
    add_row(ACT_INSERT, MaxValue, 1'b1, mk_rsp(ST_OK, 1'b0, 2, MinValue, MaxValue, 1'b0));
    add_row(ACT_INSERT, 0, 1'b0, '0);
    add_row(ACT_INSERT, 0, 1'b0, '0);
    add_row(ACT_SEARCH, 0, 1'b0, '0);
    add_row(ACT_DELETE, 1, 1'b1, mk_rsp(ST_ABSENT, 1'b0, 4, MinValue, MaxValue, 1'b0));
    add_row(ACT_DELETE, 0, 1'b0, '0);
    for (int i = 1; i <= 13; i++) add_row(ACT_INSERT, (i % 2) ? i * 1000 : -i * 1000, 1'b0, '0);
    add_row(ACT_INSERT, 3, 1'b1, mk_rsp(ST_FULL, 1'b0, Capacity, MinValue, MaxValue, 1'b0));
    add_row(ACT_DELETE, MaxValue, 1'b0, '0);
    add_row(ACT_SEARCH, MaxValue, 1'b0, '0);

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) send_word(stim_table[i].req, stim_table[i].typed,
                                      stim_table[i].rsp, 1'b1);
    sent = 0;
    while (sent < RandomItems) begin
      w = next_random_req();
      send_word(w, 1'b0, '0, !(sent >= 250 && sent < 400));
      if (w.action != ActUnused) sent++;
    end
    in_valid <= 1'b0;

    while (rsp_expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("** sorted_list_engine: PASSED **");
    end else begin
      $display("** sorted_list_engine: FAILED **");
    end
    $finish;
  end

endmodule
